/* sv/lpht_pkg.sv */
package lpht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_BYTES   = 8;
    localparam int NODE_DEPTH  = TABLE_DEPTH / 2;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int NODE_W      = $clog2(NODE_DEPTH);
    localparam int ENT_W       = IDX_W + 1;
    localparam int SIZE_W      = 11;

    typedef logic [2:0] t_status;
    localparam t_status ST_NOT_FOUND = 3'd0;
    localparam t_status ST_FOUND     = 3'd1;
    localparam t_status ST_INSERTED  = 3'd2;
    localparam t_status ST_PRESENT   = 3'd3;
    localparam t_status ST_READ_ONLY = 3'd4;
    localparam t_status ST_TOO_LONG  = 3'd5;
    localparam t_status ST_FULL      = 3'd6;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TABLE_SIZE = 2'd0;
    localparam t_cfg_idx CFG_MAX_KEY    = 2'd1;
    localparam t_cfg_idx CFG_VAL_BYTES  = 2'd2;
    localparam t_cfg_idx CFG_WRITE_OK   = 2'd3;

    localparam logic [63:0] HASH_SEED = 64'd5381;

    // byte mask for the low len bytes (len >= 8 gives all ones)
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < len) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

/* sv/linear_probe_hash_table_unit.sv */
// Channel | Direction | Handshake                     | Payload
// in      | input     | i_in_valid / o_in_ready       | action, key_bytes, key_length, value_in
// out     | output    | o_out_valid / i_out_ready     | status, value_out, slot_index
// cfg     | input     | i_cfg_valid / o_cfg_ready     | cfg_index, cfg_data
//
// One word at a time. Hash: the key bytes are folded in one by one. Modulo by table
// size: one quotient bit per cycle. Probe: index read, node read, compare per occupied
// slot visited; an empty slot ends a walk after the two reads; insert adds a write.
// Then S_OUT loads the result and returns to idle; words refused up front go straight
// to S_OUT. Reset clears the index RAM in a pass over all TABLE_DEPTH entries before
// the first word is accepted. A stalled result holds the engine; config is always taken.
module linear_probe_hash_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [63:0] i_key_bytes,
    input  logic [3:0]  i_key_length,
    input  logic [63:0] i_value_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [63:0] o_value_out,
    output logic [9:0]  o_slot_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import lpht_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_HASH  = 9'b000000100,
        S_MOD   = 9'b000001000,
        S_IRD   = 9'b000010000,
        S_NRD   = 9'b000100000,
        S_CMP   = 9'b001000000,
        S_WR    = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // config registers
    logic [SIZE_W-1:0] r_table_size;
    logic [3:0]        r_max_key;
    logic [3:0]        r_val_bytes;
    logic              r_write_ok;

    // item registers
    logic              r_action;
    logic [63:0]       r_key;
    logic [3:0]        r_len;
    logic [63:0]       r_value;
    logic [63:0]       r_hash;
    logic [3:0]        r_cnt;
    logic [6:0]        r_bit;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_size;
    logic [IDX_W-1:0]  r_slot;
    logic [SIZE_W-1:0] r_probes;
    logic [ENT_W-1:0]  r_used;
    logic              r_clr_done;
    logic [IDX_W-1:0]  r_clr_addr;
    t_status           r_wstatus;
    logic [63:0]       r_wvout;
    logic [IDX_W-1:0]  r_wslot;

    // result registers
    logic              r_out_valid;
    t_status           r_status;
    logic [63:0]       r_vout;
    logic [IDX_W-1:0]  r_oslot;

    // memories
    logic [IDX_W-1:0]  idx_mem [TABLE_DEPTH];
    logic [63:0]       key_mem [NODE_DEPTH];
    logic [3:0]        len_mem [NODE_DEPTH];
    logic [63:0]       val_mem [NODE_DEPTH];
    logic [IDX_W-1:0]  r_idx_rd;
    logic [63:0]       r_key_rd;
    logic [3:0]        r_len_rd;
    logic [63:0]       r_val_rd;

    logic              idx_we;
    logic [IDX_W-1:0]  idx_waddr;
    logic [IDX_W-1:0]  idx_wdata;
    logic              node_we;
    logic [NODE_W-1:0] node_addr;

    logic              in_acc;
    logic [SIZE_W-1:0] eff_size;
    logic [SIZE_W:0]   rem_sh;
    logic [SIZE_W-1:0] half_size;
    logic              hit;
    logic [SIZE_W-1:0] slot_inc;

    assign o_in_ready  = (r_state == S_IDLE) && r_clr_done;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value_out = r_vout;
    assign o_slot_index = r_oslot;

    // clamp table size into 3..TABLE_DEPTH
    always_comb begin
        if (r_table_size < SIZE_W'(3)) begin
            eff_size = SIZE_W'(3);
        end else if (r_table_size > SIZE_W'(TABLE_DEPTH)) begin
            eff_size = SIZE_W'(TABLE_DEPTH);
        end else begin
            eff_size = r_table_size;
        end
    end
    assign half_size = eff_size >> 1;

    // restoring remainder step, one hash bit per cycle
    assign rem_sh = {r_rem, r_hash[63 - r_bit[5:0]]};

    assign hit = (r_idx_rd != '0) && (r_len_rd == r_len) && (r_key_rd == r_key);
    assign slot_inc = SIZE_W'(r_slot) + SIZE_W'(1);

    // memory write controls
    always_comb begin
        idx_we    = 1'b0;
        idx_waddr = r_slot;
        idx_wdata = r_used[IDX_W-1:0] + IDX_W'(1);
        node_we   = 1'b0;
        node_addr = r_idx_rd[NODE_W-1:0] - NODE_W'(1);
        if (r_state == S_CLEAR) begin
            idx_we    = 1'b1;
            idx_waddr = r_clr_addr;
            idx_wdata = '0;
        end else if (r_state == S_WR) begin
            idx_we    = 1'b1;
            node_we   = 1'b1;
            node_addr = r_used[NODE_W-1:0];
        end
    end

    // index RAM
    always_ff @(posedge i_clk) begin
        if (idx_we) begin
            idx_mem[idx_waddr] <= idx_wdata;
        end
        r_idx_rd <= idx_mem[r_slot];
    end

    // node RAMs
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            key_mem[node_addr] <= r_key;
            len_mem[node_addr] <= r_len;
            val_mem[node_addr] <= r_value & byte_mask(r_val_bytes);
        end
        r_key_rd <= key_mem[node_addr];
        r_len_rd <= len_mem[node_addr];
        r_val_rd <= val_mem[node_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_addr == IDX_W'(TABLE_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    if (i_action && !r_write_ok) begin
                        n_state = S_OUT;
                    end else if (i_action && (i_key_length > 4'(KEY_BYTES) ||
                                              i_key_length >= r_max_key)) begin
                        n_state = S_OUT;
                    end else if (i_action && ENT_W'(half_size) <= r_used) begin
                        n_state = S_OUT;
                    end else if (i_key_length > 4'(KEY_BYTES)) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH:  if (r_cnt >= r_len) n_state = S_MOD;
            S_MOD:   if (r_bit == 7'd63) n_state = S_IRD;
            S_IRD:   n_state = S_NRD;
            S_NRD: begin
                if (r_idx_rd == '0) begin
                    n_state = (r_action && r_used < ENT_W'(NODE_DEPTH)) ? S_WR : S_OUT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (hit || r_probes == r_size - SIZE_W'(1)) n_state = S_OUT;
                else n_state = S_IRD;
            end
            S_WR:    n_state = S_OUT;
            S_OUT:   if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_done   <= 1'b0;
            r_clr_addr   <= '0;
            r_used       <= '0;
            r_out_valid  <= 1'b0;
            r_table_size <= SIZE_W'(7);
            r_max_key    <= 4'd9;
            r_val_bytes  <= 4'd8;
            r_write_ok   <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
                if (r_clr_addr == IDX_W'(TABLE_DEPTH - 1)) r_clr_done <= 1'b1;
            end
            if (r_state == S_WR) r_used <= r_used + ENT_W'(1);
            // result register: load when the engine finishes, else drop on take
            if (r_state == S_OUT && n_state == S_IDLE) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TABLE_SIZE: r_table_size <= i_cfg_data[SIZE_W-1:0];
                    CFG_MAX_KEY:    r_max_key    <= i_cfg_data[3:0];
                    CFG_VAL_BYTES:  r_val_bytes  <= (i_cfg_data[3:0] > 4'd8) ?
                                                    4'd8 : i_cfg_data[3:0];
                    CFG_WRITE_OK:   r_write_ok   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_action <= i_action;
                r_key    <= i_key_bytes & byte_mask(i_key_length);
                r_len    <= i_key_length;
                r_value  <= i_value_in;
                r_hash   <= HASH_SEED;
                r_cnt    <= '0;
                r_bit    <= '0;
                r_rem    <= '0;
                r_size   <= eff_size;
                r_probes <= '0;
                r_wvout  <= '0;
                r_wslot  <= '0;
                if (i_action && !r_write_ok)       r_wstatus <= ST_READ_ONLY;
                else if (i_action && (i_key_length > 4'(KEY_BYTES) ||
                                      i_key_length >= r_max_key))
                                                   r_wstatus <= ST_TOO_LONG;
                else if (i_action)                 r_wstatus <= ST_FULL;
                else                               r_wstatus <= ST_NOT_FOUND;
            end
            S_HASH: begin
                if (r_cnt < r_len) begin
                    r_hash <= ((r_hash << 5) + r_hash) ^ {56'd0, r_key[r_cnt[2:0]*8 +: 8]};
                    r_cnt  <= r_cnt + 4'd1;
                end
            end
            S_MOD: begin
                r_bit <= r_bit + 7'd1;
                if (rem_sh >= {1'b0, r_size}) begin
                    r_rem <= SIZE_W'(rem_sh - {1'b0, r_size});
                    if (r_bit == 7'd63) r_slot <= IDX_W'(rem_sh - {1'b0, r_size});
                end else begin
                    r_rem <= rem_sh[SIZE_W-1:0];
                    if (r_bit == 7'd63) r_slot <= rem_sh[IDX_W-1:0];
                end
            end
            S_CMP: begin
                if (hit) begin
                    r_wslot   <= r_slot;
                    r_wstatus <= r_action ? ST_PRESENT : ST_FOUND;
                    r_wvout   <= r_action ? 64'd0 : r_val_rd;
                end else begin
                    r_probes <= r_probes + SIZE_W'(1);
                    r_slot   <= (slot_inc >= r_size) ? '0 : slot_inc[IDX_W-1:0];
                end
            end
            S_WR: begin
                r_wslot   <= r_slot;
                r_wstatus <= ST_INSERTED;
            end
            S_OUT: begin
                // move the finished word into the result register
                if (n_state == S_IDLE) begin
                    r_status <= r_wstatus;
                    r_vout   <= r_wvout;
                    r_oslot  <= r_wslot;
                end
            end
            default: ;
        endcase
    end

    // assertions
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE)
        else $error("input ready outside idle");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= ENT_W'(NODE_DEPTH))
        else $error("entry count overflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result dropped");
    a_ins_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR |-> SIZE_W'(r_slot) < r_size)
        else $error("insert slot out of range");

endmodule
